### rtl/mrt_pkg.sv
// Shared types, operation and status codes for the mapping region table.
package mrt_pkg;

   localparam logic [2:0] KIND_CLEAR      = 3'd0;
   localparam logic [2:0] KIND_ADD_ENTRY  = 3'd1;
   localparam logic [2:0] KIND_ADD_MEMORY = 3'd2;
   localparam logic [2:0] KIND_ADD_KMMAP  = 3'd3;
   localparam logic [2:0] KIND_READ       = 3'd4;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_ALIGN    = 3'd2;
   localparam logic [2:0] STATUS_OVERLAP  = 3'd3;
   localparam logic [2:0] STATUS_NOSPACE  = 3'd4;
   localparam logic [2:0] STATUS_BADIDX   = 3'd5;

   localparam logic [1:0] CSR_KERNEL_BASE = 2'd0;
   localparam logic [1:0] CSR_KMAP_START  = 2'd1;
   localparam logic [1:0] CSR_RESV_START  = 2'd2;

   localparam logic [31:0] KERNEL_BASE_RST = 32'h8000_0000;
   localparam logic [31:0] KMAP_START_RST  = 32'hC000_0000;
   localparam logic [31:0] RESV_START_RST  = 32'hF000_0000;

   // Request token that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  status;    // result of the checks done before launch
      logic        hit;       // overlap seen in an earlier cell
      logic [3:0]  index;
      logic [31:0] phys;
      logic [31:0] virt;
      logic [31:0] len;
      logic        rtype;
      logic [32:0] vend;      // virt + len, 33 bits
      logic [31:0] rd_phys;
      logic [31:0] rd_virt;
      logic [31:0] rd_len;
      logic        rd_type;
   } token_type;

   function automatic logic kind_is_add(input logic [2:0] kind);
      return kind inside {KIND_ADD_ENTRY, KIND_ADD_MEMORY, KIND_ADD_KMMAP};
   endfunction

endpackage

### rtl/mapping_region_table_unit.sv
// Top level of the mapping region table: request control, bump pointers and the cell row.
//
//   channel   ports           direction   contents
//   request   req_*           in          kind, bases, length, type, index
//   response  rsp_*           out         status, phys, virt, length, type
//   csr       csr_*           in          write of kernel/kmmap/reserved base
//
// A request passes from acceptance through the launch checks, which feed cell 0,
// then through each cell of the row in turn and into the response register.
// Only one request is in flight at a time; a new one is accepted while a finished
// response waits, but it only launches once the response register is empty.
// Reset is synchronous; it empties the table and loads both bump pointers.
module mapping_region_table_unit
   import mrt_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int PAGE_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_phys_base,
   input  logic [31:0] req_virt_base,
   input  logic [31:0] req_length,
   input  logic        req_region_type,
   input  logic [3:0]  req_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_phys,
   output logic [31:0] rsp_result_virt,
   output logic [31:0] rsp_result_length,
   output logic        rsp_result_type,

   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_HELD = 3'b010,
      FSM_RUN  = 3'b100
   } state_type;

   state_type   state_ff, state_in;

   logic [31:0] kernel_base_ff, kmap_start_ff, resv_start_ff;

   logic [2:0]  req_kind_ff;
   logic [31:0] req_phys_ff, req_virt_ff, req_len_ff;
   logic        req_type_ff;
   logic [3:0]  req_index_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [32:0]   memory_top_ff, memory_top_in;
   logic [32:0]   kmap_top_ff, kmap_top_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_phys_ff, rsp_virt_ff, rsp_len_ff;
   logic        rsp_type_ff;

   logic        accept;
   logic        launch;
   logic        retire;

   token_type   launch_tok;
   logic [32:0] room_mem, room_kmm;
   logic [31:0] eff_virt, eff_len;
   logic        eff_type;
   logic        nospace, full, misal;

   logic        valid_chain [ENTRIES+1];
   token_type   tok_chain   [ENTRIES+1];

   token_type   tail;
   logic [2:0]  fin_status;
   logic        add_ok;

   assign accept = req_valid && !req_stall;
   assign launch = (state_ff == FSM_HELD) && !rsp_valid_ff;
   assign retire = (state_ff == FSM_RUN) && valid_chain[ENTRIES];

   assign req_stall = (state_ff != FSM_IDLE);

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_base_ff <= KERNEL_BASE_RST;
         kmap_start_ff  <= KMAP_START_RST;
         resv_start_ff  <= RESV_START_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KERNEL_BASE: kernel_base_ff <= csr_data;
            CSR_KMAP_START:  kmap_start_ff  <= csr_data;
            CSR_RESV_START:  resv_start_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         req_kind_ff  <= req_kind;
         req_phys_ff  <= req_phys_base;
         req_virt_ff  <= req_virt_base;
         req_len_ff   <= req_length;
         req_type_ff  <= req_region_type;
         req_index_ff <= req_index;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_HELD;
         FSM_HELD: if (launch) state_in = FSM_RUN;
         FSM_RUN:  if (retire) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- launch checks ----------------
   assign room_mem = {1'b0, kmap_start_ff} - memory_top_ff;
   assign room_kmm = {1'b0, resv_start_ff} - kmap_top_ff;
   assign full     = count_ff >= CW'(ENTRIES);

   always_comb begin
      nospace  = 1'b0;
      eff_virt = req_virt_ff;
      eff_len  = req_len_ff;
      eff_type = req_type_ff;
      case (req_kind_ff)
         KIND_ADD_MEMORY: begin
            nospace  = memory_top_ff >= {1'b0, kmap_start_ff};
            eff_virt = memory_top_ff[31:0];
            eff_type = 1'b0;
            if ({1'b0, req_len_ff} > room_mem) begin
               eff_len = room_mem[31:0];
            end
         end
         KIND_ADD_KMMAP: begin
            nospace  = (kmap_top_ff >= {1'b0, resv_start_ff}) ||
                       ({1'b0, req_len_ff} > room_kmm);
            eff_virt = kmap_top_ff[31:0];
            eff_type = 1'b1;
         end
         default: ;
      endcase
   end

   assign misal = ((req_phys_ff & PAGE_MASK) != 32'd0) ||
                  ((eff_virt & PAGE_MASK) != 32'd0) ||
                  ((eff_len & PAGE_MASK) != 32'd0);

   always_comb begin
      launch_tok        = '0;
      launch_tok.kind   = req_kind_ff;
      launch_tok.index  = req_index_ff;
      launch_tok.phys   = req_phys_ff;
      launch_tok.virt   = eff_virt;
      launch_tok.len    = eff_len;
      launch_tok.rtype  = eff_type;
      launch_tok.vend   = {1'b0, eff_virt} + {1'b0, eff_len};
      launch_tok.status = STATUS_OK;
      if (kind_is_add(req_kind_ff)) begin
         if (nospace) begin
            launch_tok.status = STATUS_NOSPACE;
         end else if (full) begin
            launch_tok.status = STATUS_FULL;
         end else if (misal) begin
            launch_tok.status = STATUS_ALIGN;
         end
      end else if (req_kind_ff == KIND_READ) begin
         if (!(32'(req_index_ff) < 32'(count_ff))) begin
            launch_tok.status = STATUS_BADIDX;
         end
      end
   end

   // ---------------- cell row ----------------
   assign valid_chain[0] = launch;
   assign tok_chain[0]   = launch_tok;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mrt_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .in_valid  (valid_chain[i]),
         .in_tok    (tok_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_tok   (tok_chain[i+1])
      );
   end

   // ---------------- retire ----------------
   assign tail = tok_chain[ENTRIES];

   always_comb begin
      fin_status = tail.status;
      if ((tail.status == STATUS_OK) && kind_is_add(tail.kind) && tail.hit) begin
         fin_status = STATUS_OVERLAP;
      end
   end

   assign add_ok = kind_is_add(tail.kind) && (fin_status == STATUS_OK);

   always_comb begin
      count_in      = count_ff;
      memory_top_in = memory_top_ff;
      kmap_top_in   = kmap_top_ff;
      if (retire) begin
         if (tail.kind == KIND_CLEAR) begin
            count_in      = '0;
            memory_top_in = {1'b0, kernel_base_ff};
            kmap_top_in   = {1'b0, kmap_start_ff};
         end else if (add_ok) begin
            count_in = count_ff + CW'(1);
            if (tail.kind == KIND_ADD_MEMORY) begin
               memory_top_in = memory_top_ff + {1'b0, tail.len};
            end
            if (tail.kind == KIND_ADD_KMMAP) begin
               kmap_top_in = kmap_top_ff + {1'b0, tail.len};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         memory_top_ff <= {1'b0, KERNEL_BASE_RST};
         kmap_top_ff   <= {1'b0, KMAP_START_RST};
      end else begin
         count_ff      <= count_in;
         memory_top_ff <= memory_top_in;
         kmap_top_ff   <= kmap_top_in;
      end
   end

   // ---------------- response register ----------------
   assign rsp_valid_in = retire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_status_ff <= fin_status;
         rsp_phys_ff   <= tail.rd_phys;
         rsp_virt_ff   <= add_ok ? tail.virt : tail.rd_virt;
         rsp_len_ff    <= add_ok ? tail.len : tail.rd_len;
         rsp_type_ff   <= tail.rd_type;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_phys   = rsp_phys_ff;
   assign rsp_result_virt   = rsp_virt_ff;
   assign rsp_result_length = rsp_len_ff;
   assign rsp_result_type   = rsp_type_ff;

endmodule

### rtl/mrt_cell.sv
// One table slot: holds an entry, checks overlap and serves reads as the token passes.
module mrt_cell
   import mrt_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] count,
   input  logic          in_valid,
   input  token_type     in_tok,
   output logic          out_valid,
   output token_type     out_tok
);

   localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);

   logic [31:0] e_phys_ff;
   logic [31:0] e_virt_ff;
   logic [31:0] e_len_ff;
   logic [32:0] e_end_ff;
   logic        e_type_ff;

   logic        valid_ff;
   token_type   tok_ff;
   token_type   tok_in;

   logic        occupied;
   logic        meet;
   logic        wr;
   logic        rd;
   logic        is_add;

   assign occupied = MY_SLOT < count;
   assign is_add   = kind_is_add(in_tok.kind);

   assign meet = occupied && (in_tok.len != 32'd0) && (e_len_ff != 32'd0) &&
                 ({1'b0, in_tok.virt} < e_end_ff) && ({1'b0, e_virt_ff} < in_tok.vend);

   // All occupied slots sit before the first free one, so hit is complete here.
   assign wr = in_valid && is_add && (in_tok.status == STATUS_OK) && !in_tok.hit &&
               (count == MY_SLOT);

   assign rd = in_valid && (in_tok.kind == KIND_READ) && occupied &&
               (int'(in_tok.index) == INDEX);

   always_comb begin
      tok_in = in_tok;
      if (is_add && meet) begin
         tok_in.hit = 1'b1;
      end
      if (rd) begin
         tok_in.rd_phys = e_phys_ff;
         tok_in.rd_virt = e_virt_ff;
         tok_in.rd_len  = e_len_ff;
         tok_in.rd_type = e_type_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (wr) begin
         e_phys_ff <= in_tok.phys;
         e_virt_ff <= in_tok.virt;
         e_len_ff  <= in_tok.len;
         e_end_ff  <= in_tok.vend;
         e_type_ff <= in_tok.rtype;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

### rtl/mrt_checker.sv
// Port-level assertions for the mapping region table, bound to the top level.
module mrt_checker
   import mrt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_result_phys,
   input logic [31:0] rsp_result_virt,
   input logic [31:0] rsp_result_length,
   input logic        rsp_result_type
);

   // stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_result_virt) &&
                                 $stable(rsp_result_length))
      else $error("stalled response changed");

   // any failure returns an empty result
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_result_phys == 32'd0) && (rsp_result_virt == 32'd0) &&
         (rsp_result_length == 32'd0) && (rsp_result_type == 1'b0))
      else $error("failed request returned data");

   // one request at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted back to back");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_FULL) ||
                    (rsp_status == STATUS_ALIGN) || (rsp_status == STATUS_OVERLAP) ||
                    (rsp_status == STATUS_NOSPACE) || (rsp_status == STATUS_BADIDX))
      else $error("status code out of range");

endmodule

bind mapping_region_table_unit mrt_checker u_mrt_checker (.*);

### dv/region_table_check_pkg.sv
`timescale 1ns / 1ps
// Request and response types plus the scoreboard that predicts the mapping region table.
package region_table_check_pkg;
   import mrt_pkg::*;

   localparam int          SLOTS      = 16;
   localparam int          PAGE_SHIFT = 12;
   localparam logic [31:0] PAGE_MASK  = (32'd1 << PAGE_SHIFT) - 32'd1;

   // Kinds outside the defined set are no-ops that still answer.
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] phys;
      logic [31:0] virt;
      logic [31:0] len;
      logic        rtype;
      logic [3:0]  index;
   } region_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] phys;
      logic [31:0] virt;
      logic [31:0] len;
      logic        rtype;
   } region_result_type;

   // Zero-length ranges never meet; ends are taken at 33 bits.
   function automatic bit ranges_meet(logic [31:0] a_virt, logic [31:0] a_len,
                                      logic [31:0] b_virt, logic [31:0] b_len);
      logic [32:0] a_end;
      logic [32:0] b_end;
      a_end = {1'b0, a_virt} + {1'b0, a_len};
      b_end = {1'b0, b_virt} + {1'b0, b_len};
      if (a_len == 32'd0 || b_len == 32'd0) return 1'b0;
      return ({1'b0, a_virt} < b_end) && ({1'b0, b_virt} < a_end);
   endfunction

   class region_table_scoreboard;
      logic [31:0]       kernel_base;
      logic [31:0]       kmap_start;
      logic [31:0]       resv_start;
      logic [31:0]       slot_phys [SLOTS];
      logic [31:0]       slot_virt [SLOTS];
      logic [31:0]       slot_len  [SLOTS];
      logic              slot_type [SLOTS];
      int unsigned       used;
      logic [32:0]       memory_top;
      logic [32:0]       kmap_top;
      region_result_type results_due [$];
      int unsigned       errors;

      function new();
         errors      = 0;
         kernel_base = KERNEL_BASE_RST;
         kmap_start  = KMAP_START_RST;
         resv_start  = RESV_START_RST;
         used        = 0;
         memory_top  = {1'b0, KERNEL_BASE_RST};
         kmap_top    = {1'b0, KMAP_START_RST};
      endfunction

      function int unsigned outstanding();
         return results_due.size();
      endfunction

      // Register writes leave the bump pointers alone; only clear reloads them.
      function void write_register(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_KERNEL_BASE: kernel_base = value;
            CSR_KMAP_START:  kmap_start = value;
            CSR_RESV_START:  resv_start = value;
            default: ;
         endcase
      endfunction

      function logic [2:0] insert_entry(logic [31:0] phys, logic [31:0] virt,
                                        logic [31:0] len, logic rtype);
         int i;
         if (used >= SLOTS) return STATUS_FULL;
         if (((phys | virt | len) & PAGE_MASK) != 32'd0) return STATUS_ALIGN;
         for (i = 0; i < used; i++)
            if (ranges_meet(virt, len, slot_virt[i], slot_len[i])) return STATUS_OVERLAP;
         slot_phys[used] = phys;
         slot_virt[used] = virt;
         slot_len[used]  = len;
         slot_type[used] = rtype;
         used++;
         return STATUS_OK;
      endfunction

      function void note_request(region_request_type r);
         region_result_type res;
         logic [31:0]       room;
         logic [31:0]       grant;
         res = '0;
         case (r.kind)
            KIND_CLEAR: begin
               used       = 0;
               memory_top = {1'b0, kernel_base};
               kmap_top   = {1'b0, kmap_start};
            end
            KIND_ADD_ENTRY: begin
               res.status = insert_entry(r.phys, r.virt, r.len, r.rtype);
               if (res.status == STATUS_OK) begin
                  res.virt = r.virt;
                  res.len  = r.len;
               end
            end
            KIND_ADD_MEMORY: begin
               if (memory_top >= {1'b0, kmap_start}) begin
                  res.status = STATUS_NOSPACE;
               end else begin
                  // length is clipped at the kmmap boundary
                  room  = kmap_start - memory_top[31:0];
                  grant = (r.len > room) ? room : r.len;
                  res.status = insert_entry(r.phys, memory_top[31:0], grant, 1'b0);
                  if (res.status == STATUS_OK) begin
                     res.virt   = memory_top[31:0];
                     res.len    = grant;
                     memory_top = memory_top + {1'b0, grant};
                  end
               end
            end
            KIND_ADD_KMMAP: begin
               if (kmap_top >= {1'b0, resv_start} ||
                   {1'b0, r.len} > {1'b0, resv_start} - kmap_top) begin
                  res.status = STATUS_NOSPACE;
               end else begin
                  res.status = insert_entry(r.phys, kmap_top[31:0], r.len, 1'b1);
                  if (res.status == STATUS_OK) begin
                     res.virt = kmap_top[31:0];
                     res.len  = r.len;
                     kmap_top = kmap_top + {1'b0, r.len};
                  end
               end
            end
            KIND_READ: begin
               if (r.index < used) begin
                  res.phys  = slot_phys[r.index];
                  res.virt  = slot_virt[r.index];
                  res.len   = slot_len[r.index];
                  res.rtype = slot_type[r.index];
               end else begin
                  res.status = STATUS_BADIDX;
               end
            end
            default: ;
         endcase
         results_due.push_back(res);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(region_result_type got);
         region_result_type want;
         if (results_due.size() == 0) begin
            $error("response with no request outstanding (status %0d)", got.status);
            errors++;
            return;
         end
         want = results_due.pop_front();
         compare_field("status", {29'd0, want.status}, {29'd0, got.status});
         compare_field("result_phys", want.phys, got.phys);
         compare_field("result_virt", want.virt, got.virt);
         compare_field("result_length", want.len, got.len);
         compare_field("result_type", {31'd0, want.rtype}, {31'd0, got.rtype});
      endfunction
   endclass

endpackage

### dv/mapping_region_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and CSR windows, checks every response against the scoreboard.
module mapping_region_table_unit_tb;
   import mrt_pkg::*;
   import region_table_check_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int CALM_TAIL    = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = KIND_CLEAR;
   logic [31:0] req_phys_base = 32'd0;
   logic [31:0] req_virt_base = 32'd0;
   logic [31:0] req_length = 32'd0;
   logic        req_region_type = 1'b0;
   logic [3:0]  req_index = 4'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_phys;
   logic [31:0] rsp_result_virt;
   logic [31:0] rsp_result_length;
   logic        rsp_result_type;

   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_KERNEL_BASE;
   logic [31:0] csr_data = 32'd0;

   region_table_scoreboard book;
   bit          gap_on = 1'b1;
   bit          stall_on = 1'b1;
   int          stall_left = 0;
   int unsigned cycle_count = 0;

   mapping_region_table_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_phys_base     (req_phys_base),
      .req_virt_base     (req_virt_base),
      .req_length        (req_length),
      .req_region_type   (req_region_type),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_phys   (rsp_result_phys),
      .rsp_result_virt   (rsp_result_virt),
      .rsp_result_length (rsp_result_length),
      .rsp_result_type   (rsp_result_type),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Response side: values read here are the ones sampled at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         book.check_response('{rsp_status, rsp_result_phys, rsp_result_virt,
                                rsp_result_length, rsp_result_type});
      if (!stall_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic region_request_type request_of(logic [2:0] kind, logic [31:0] phys,
                                                     logic [31:0] virt, logic [31:0] len,
                                                     logic rtype, logic [3:0] index);
      region_request_type r;
      r = '{kind, phys, virt, len, rtype, index};
      return r;
   endfunction

   function automatic logic [31:0] random_page();
      logic [31:0] v;
      v = $urandom;
      return v & ~PAGE_MASK;
   endfunction

   // Mostly aligned requests packed into a few narrow windows so that
   // overlaps, a full table and window exhaustion all come up often.
   function automatic region_request_type random_request();
      region_request_type r;
      int unsigned        pick;
      int unsigned        shape;
      pick = $urandom_range(0, 99);
      if (pick < 3)        r.kind = KIND_CLEAR;
      else if (pick < 38)  r.kind = KIND_ADD_ENTRY;
      else if (pick < 52)  r.kind = KIND_ADD_MEMORY;
      else if (pick < 66)  r.kind = KIND_ADD_KMMAP;
      else if (pick < 96)  r.kind = KIND_READ;
      else r.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));

      r.phys = ($urandom_range(0, 9) == 0) ? $urandom : random_page();

      shape = $urandom_range(0, 9);
      if (shape == 0)      r.virt = $urandom;
      else if (shape == 1) r.virt = 32'hFFFF_F000 - ($urandom_range(0, 15) << PAGE_SHIFT);
      else                 r.virt = 32'h0040_0000 + ($urandom_range(0, 63) << PAGE_SHIFT);

      shape = $urandom_range(0, 11);
      if (shape == 0)      r.len = $urandom;
      else if (shape == 1) r.len = 32'd0;
      else if (shape == 2) r.len = random_page();
      else                 r.len = $urandom_range(1, 8) << PAGE_SHIFT;

      r.rtype = 1'($urandom_range(0, 1));
      r.index = 4'($urandom_range(0, 15));
      return r;
   endfunction

   // Valid stays high after acceptance; a gap lowers it first.
   task automatic send_request(input region_request_type r);
      if (gap_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_phys_base   <= r.phys;
      req_virt_base   <= r.virt;
      req_length      <= r.len;
      req_region_type <= r.rtype;
      req_index       <= r.index;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      book.note_request(r);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.outstanding() != 0) @(posedge clock);
   endtask

   task automatic set_windows(input logic [31:0] kernel, input logic [31:0] kmmap,
                              input logic [31:0] reserved);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KERNEL_BASE;
      csr_data  <= kernel;
      @(posedge clock);
      book.write_register(CSR_KERNEL_BASE, kernel);
      csr_index <= CSR_KMAP_START;
      csr_data  <= kmmap;
      @(posedge clock);
      book.write_register(CSR_KMAP_START, kmmap);
      csr_index <= CSR_RESV_START;
      csr_data  <= reserved;
      @(posedge clock);
      book.write_register(CSR_RESV_START, reserved);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count, input bit calm_tail);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            gap_on   = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
         end
         if (calm_tail && n >= count - CALM_TAIL) begin
            gap_on   = 1'b0;
            stall_on = 1'b0;
         end
         if ($urandom_range(0, 199) == 0) go_quiet();
         send_request(random_request());
      end
   endtask

   initial begin
      int phase;
      int k;
      book = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset windows, memory at 0x8000_0000, kmmap 0xC000_0000..0xF000_0000
      send_request(request_of(KIND_READ, 32'd0, 32'd0, 32'd0, 1'b0, 4'hF));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_1000, 32'h0010_0000, 32'h2000, 1'b1, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_2000, 32'h0010_1000, 32'h1000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_3000, 32'h000F_F000, 32'h1000, 1'b0, 4'h0));
      // zero length sits inside an existing range without overlapping
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_4000, 32'h0010_0000, 32'h0, 1'b1, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'hFFFF_FFFF, 32'h0020_0000, 32'h1000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_5000, 32'h0020_0800, 32'h1000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_5000, 32'h0020_0000, 32'h0FFF, 1'b0, 4'h0));
      // last page of the address space: end needs the 33rd bit
      send_request(request_of(KIND_ADD_ENTRY, 32'hFFFF_F000, 32'hFFFF_F000, 32'h1000, 1'b1, 4'h0));
      send_request(request_of(KIND_ADD_ENTRY, 32'h0000_6000, 32'hFFFF_E000, 32'h2000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_MEMORY, 32'h0000_0000, 32'd0, 32'h4000, 1'b1, 4'h0));
      send_request(request_of(KIND_ADD_MEMORY, 32'h0010_0000, 32'd0, 32'hFFFF_F000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_MEMORY, 32'h0020_0000, 32'd0, 32'h1000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_KMMAP, 32'h0030_0000, 32'd0, 32'h3000_0000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_KMMAP, 32'h0040_0000, 32'd0, 32'h0, 1'b0, 4'h0));
      send_request(request_of(KIND_READ, 32'd0, 32'd0, 32'd0, 1'b0, 4'h0));
      send_request(request_of(KIND_READ, 32'd0, 32'd0, 32'd0, 1'b0, 4'h6));
      send_request(request_of(KIND_READ, 32'd0, 32'd0, 32'd0, 1'b0, 4'h7));
      for (k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_request(request_of(3'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 1'b1, 4'hF));
      send_request(request_of(KIND_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0, 4'h0));
      send_request(request_of(KIND_READ, 32'd0, 32'd0, 32'd0, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_MEMORY, 32'h0000_7000, 32'd0, 32'h1000, 1'b0, 4'h0));
      send_request(request_of(KIND_ADD_KMMAP, 32'h0000_8000, 32'd0, 32'h1000, 1'b0, 4'h0));

      run_random(180, 1'b0);

      for (phase = 0; phase < 6; phase++) begin
         go_quiet();
         case (phase)
            0: set_windows(32'h1000_0000, 32'h1002_0000, 32'h1004_0000);
            1: set_windows(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
            2: set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: set_windows(32'h0000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF);
            4: set_windows(32'h0000_0800, 32'h0001_0800, 32'h0002_0000);
            default: set_windows(KERNEL_BASE_RST, KMAP_START_RST, RESV_START_RST);
         endcase
         // the all-ones window keeps the previous bump pointers until a random clear
         if (phase != 2)
            send_request(request_of(KIND_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0, 4'h0));
         if (phase == 5) run_random(300, 1'b1);
         else            run_random(130, 1'b0);
      end

      go_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
rtl/mrt_pkg.sv
rtl/mrt_cell.sv
rtl/mapping_region_table_unit.sv
rtl/mrt_checker.sv
dv/region_table_check_pkg.sv
dv/mapping_region_table_unit_tb.sv
